// ----- hw/rtl/tfn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal package
// Shared widths and the side-band record that travels with each triangle.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // Magnitude width used from the cross product through normalization.
  localparam int MAG_W  = 63;
  // Normalized magnitude width: the top bit of the largest lands on bit 29.
  localparam int A_W    = 30;
  // Sum of three squares of A_W-bit values.
  localparam int SUM_W  = 62;
  // Square root result width.
  localparam int ROOT_W = 31;
  // Partial remainder width inside the square root chain.
  localparam int SREM_W = 34;
  // Partial remainder width inside the divider chain.
  localparam int DREM_W = 32;
  // Output component width.
  localparam int OUT_W  = 16;

  typedef logic [MAG_W-1:0] mag_t;

  // Control record that follows each triangle down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
    logic       degen;
  } side_t;

endpackage

// ----- hw/rtl/tfn_norm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normalization cell
// One step of a binary leading-zero shift over three magnitudes at once.
// ----------------------------------------------------------------------------
module tfn_norm_cell #(
  parameter int SH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  tfn_pkg::side_t side_i,
  input  tfn_pkg::mag_t  mag_i [3],
  output tfn_pkg::side_t side_o,
  output tfn_pkg::mag_t  mag_o [3]
);
  import tfn_pkg::*;

  mag_t any_bits;
  logic top_clear;

  // The OR of the three magnitudes has the same leading one as their maximum.
  assign any_bits  = mag_i[0] | mag_i[1] | mag_i[2];
  assign top_clear = (any_bits[MAG_W-1 -: SH] == '0);

  // Shift every component by the same amount when the top slice is clear.
  always_ff @(posedge clk) begin
    side_o <= rst ? '0 : side_i;
    for (int i = 0; i < 3; i++) begin
      mag_o[i] <= top_clear ? (mag_i[i] << SH) : mag_i[i];
    end
  end

endmodule

// ----- hw/rtl/tfn_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Produces one root bit per stage and carries the normalized components along.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell #(
  parameter int PW = 90
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tfn_pkg::side_t              side_i,
  input  logic [tfn_pkg::SREM_W-1:0]  rem_i,
  input  logic [tfn_pkg::ROOT_W-1:0]  root_i,
  input  logic [tfn_pkg::SUM_W-1:0]   val_i,
  input  logic [PW-1:0]               pay_i,
  output tfn_pkg::side_t              side_o,
  output logic [tfn_pkg::SREM_W-1:0]  rem_o,
  output logic [tfn_pkg::ROOT_W-1:0]  root_o,
  output logic [tfn_pkg::SUM_W-1:0]   val_o,
  output logic [PW-1:0]               pay_o
);
  import tfn_pkg::*;

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  logic              ge;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_i[SREM_W-3:0], val_i[SUM_W-1 -: 2]};
    trial  = SREM_W'({root_i, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    side_o <= rst ? '0 : side_i;
    rem_o  <= ge ? (rem_sh - trial) : rem_sh;
    root_o <= {root_i[ROOT_W-2:0], ge};
    val_o  <= val_i << 2;
    pay_o  <= pay_i;
  end

endmodule

// ----- hw/rtl/tfn_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step for three components sharing one divisor.
// ----------------------------------------------------------------------------
module tfn_div_cell #(
  parameter int QW = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tfn_pkg::side_t              side_i,
  input  logic [tfn_pkg::ROOT_W-1:0]  den_i,
  input  logic [tfn_pkg::DREM_W-1:0]  rem_i [3],
  input  logic [QW-1:0]               nq_i  [3],
  output tfn_pkg::side_t              side_o,
  output logic [tfn_pkg::ROOT_W-1:0]  den_o,
  output logic [tfn_pkg::DREM_W-1:0]  rem_o [3],
  output logic [QW-1:0]               nq_o  [3]
);
  import tfn_pkg::*;

  logic [DREM_W-1:0] t   [3];
  logic [DREM_W-1:0] den;
  logic              ge  [3];

  // Shift in the next dividend bit and compare against the divisor.
  always_comb begin
    den = DREM_W'(den_i);
    for (int i = 0; i < 3; i++) begin
      t[i]  = {rem_i[i][DREM_W-2:0], nq_i[i][QW-1]};
      ge[i] = (t[i] >= den);
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    side_o <= rst ? '0 : side_i;
    den_o  <= den_i;
    for (int i = 0; i < 3; i++) begin
      rem_o[i] <= ge[i] ? (t[i] - den) : t[i];
      nq_o[i]  <= {nq_i[i][QW-2:0], ge[i]};
    end
  end

endmodule

// ----- hw/rtl/triangle_face_normal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal
// Unit normal of a triangle from its three vertices, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one triangle in every clock cycle while busy is low and
// returns its unit normal, pulsing done for one cycle. Each triangle passes
// in order through the registers of the edges, the products and the cross
// product, the normalizing shift cells, the squaring and summing registers,
// the square root chain, the dividend setup, the divider chain and the
// output register. Results cannot be held off; done marks each one for
// exactly one cycle. busy is high only while reset is applied and in the
// cycle after.
module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] v1_x,
  input  logic signed [COORD_WIDTH-1:0] v1_y,
  input  logic signed [COORD_WIDTH-1:0] v1_z,
  input  logic signed [COORD_WIDTH-1:0] v2_x,
  input  logic signed [COORD_WIDTH-1:0] v2_y,
  input  logic signed [COORD_WIDTH-1:0] v2_z,
  input  logic signed [COORD_WIDTH-1:0] v3_x,
  input  logic signed [COORD_WIDTH-1:0] v3_y,
  input  logic signed [COORD_WIDTH-1:0] v3_z,
  output logic                          done,
  output logic signed [15:0]            norm_x,
  output logic signed [15:0]            norm_y,
  output logic signed [15:0]            norm_z,
  output logic                          degenerate
);
  import tfn_pkg::*;

  localparam int EW   = (COORD_WIDTH > 30) ? 31 : COORD_WIDTH + 1;
  localparam int ESH  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int PW   = 2 * EW;
  localparam int CW2  = PW + 1;
  localparam int QW   = NORMAL_FRAC_BITS + 1;
  localparam int NW   = A_W + NORMAL_FRAC_BITS + 1;
  localparam int NORM_STAGES = 6;
  localparam logic [QW-1:0] MAXC =
    QW'((NORMAL_FRAC_BITS >= 15) ? 32767 : (1 << NORMAL_FRAC_BITS) - 1);

  // Edge component, truncated toward zero when the coordinates are very wide.
  function automatic logic signed [EW-1:0] edge_f(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b
  );
    logic [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0] m;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    m = d[COORD_WIDTH] ? (-d) : d;
    m = m >> ESH;
    return d[COORD_WIDTH] ? EW'(-m) : EW'(m);
  endfunction

  logic accept;
  assign accept = start && !busy;

  // Busy only around reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Stage 1: edge vectors.
  side_t s1;
  logic signed [EW-1:0] ex, ey, ez, fx, fy, fz;
  always_ff @(posedge clk) begin
    s1 <= rst ? '0 : side_t'{valid: accept, neg: 3'b000, degen: 1'b0};
    ex <= edge_f(v2_x, v1_x);
    ey <= edge_f(v2_y, v1_y);
    ez <= edge_f(v2_z, v1_z);
    fx <= edge_f(v3_x, v1_x);
    fy <= edge_f(v3_y, v1_y);
    fz <= edge_f(v3_z, v1_z);
  end

  // Stage 2: the six partial products of the cross product.
  side_t s2;
  logic signed [PW-1:0] p [6];
  always_ff @(posedge clk) begin
    s2   <= rst ? '0 : s1;
    p[0] <= PW'(ey) * PW'(fz);
    p[1] <= PW'(ez) * PW'(fy);
    p[2] <= PW'(ez) * PW'(fx);
    p[3] <= PW'(ex) * PW'(fz);
    p[4] <= PW'(ex) * PW'(fy);
    p[5] <= PW'(ey) * PW'(fx);
  end

  // Stage 3: cross product, split into sign and magnitude.
  logic signed [CW2-1:0] c   [3];
  logic        [CW2-1:0] cm  [3];
  side_t s3_next;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i]  = CW2'(p[2*i]) - CW2'(p[2*i+1]);
      cm[i] = c[i][CW2-1] ? (-c[i]) : c[i];
    end
    s3_next       = s2;
    s3_next.neg   = {c[2][CW2-1], c[1][CW2-1], c[0][CW2-1]};
    s3_next.degen = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
  end

  side_t n_side [NORM_STAGES+1];
  mag_t  n_mag  [NORM_STAGES+1][3];
  always_ff @(posedge clk) begin
    n_side[0] <= rst ? '0 : s3_next;
    for (int i = 0; i < 3; i++) begin
      n_mag[0][i] <= MAG_W'(cm[i]);
    end
  end

  // Normalizing shift: 32, 16, 8, 4, 2, 1.
  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    tfn_norm_cell #(.SH(1 << (NORM_STAGES - 1 - g))) u_cell (
      .clk   (clk),
      .rst   (rst),
      .side_i(n_side[g]),
      .mag_i (n_mag[g]),
      .side_o(n_side[g+1]),
      .mag_o (n_mag[g+1])
    );
  end

  // Squares of the normalized components.
  side_t            sq_side;
  logic [A_W-1:0]   sq_a   [3];
  logic [2*A_W-1:0] sq     [3];
  always_ff @(posedge clk) begin
    sq_side <= rst ? '0 : n_side[NORM_STAGES];
    for (int i = 0; i < 3; i++) begin
      sq_a[i] <= n_mag[NORM_STAGES][i][MAG_W-1 -: A_W];
      sq[i]   <= n_mag[NORM_STAGES][i][MAG_W-1 -: A_W]
                 * n_mag[NORM_STAGES][i][MAG_W-1 -: A_W];
    end
  end

  // Sum of squares feeds the square root chain.
  side_t             rt_side [ROOT_W+1];
  logic [SREM_W-1:0] rt_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] rt_root [ROOT_W+1];
  logic [SUM_W-1:0]  rt_val  [ROOT_W+1];
  logic [3*A_W-1:0]  rt_pay  [ROOT_W+1];
  always_ff @(posedge clk) begin
    rt_side[0] <= rst ? '0 : sq_side;
    rt_rem[0]  <= '0;
    rt_root[0] <= '0;
    rt_val[0]  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    rt_pay[0]  <= {sq_a[2], sq_a[1], sq_a[0]};
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    tfn_sqrt_cell #(.PW(3 * A_W)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .side_i(rt_side[g]),
      .rem_i (rt_rem[g]),
      .root_i(rt_root[g]),
      .val_i (rt_val[g]),
      .pay_i (rt_pay[g]),
      .side_o(rt_side[g+1]),
      .rem_o (rt_rem[g+1]),
      .root_o(rt_root[g+1]),
      .val_o (rt_val[g+1]),
      .pay_o (rt_pay[g+1])
    );
  end

  // Dividend setup: a * 2^F plus half the length, for rounding.
  logic [NW-1:0] num [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({rt_pay[ROOT_W][i*A_W +: A_W], NORMAL_FRAC_BITS'(0)})
               + NW'(rt_root[ROOT_W] >> 1);
    end
  end

  side_t             dv_side [QW+1];
  logic [ROOT_W-1:0] dv_den  [QW+1];
  logic [DREM_W-1:0] dv_rem  [QW+1][3];
  logic [QW-1:0]     dv_nq   [QW+1][3];
  always_ff @(posedge clk) begin
    dv_side[0] <= rst ? '0 : rt_side[ROOT_W];
    dv_den[0]  <= rt_root[ROOT_W];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= DREM_W'(num[i] >> QW);
      dv_nq[0][i]  <= num[i][QW-1:0];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    tfn_div_cell #(.QW(QW)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .side_i(dv_side[g]),
      .den_i (dv_den[g]),
      .rem_i (dv_rem[g]),
      .nq_i  (dv_nq[g]),
      .side_o(dv_side[g+1]),
      .den_o (dv_den[g+1]),
      .rem_o (dv_rem[g+1]),
      .nq_o  (dv_nq[g+1])
    );
  end

  // Clamp, apply the sign and force zero for a degenerate triangle.
  logic [QW-1:0]    qc  [3];
  logic [OUT_W-1:0] res [3];
  side_t            fin;
  always_comb begin
    fin = dv_side[QW];
    for (int i = 0; i < 3; i++) begin
      qc[i]  = (dv_nq[QW][i] > MAXC) ? MAXC : dv_nq[QW][i];
      res[i] = fin.neg[i] ? (-OUT_W'(qc[i])) : OUT_W'(qc[i]);
      if (fin.degen) begin
        res[i] = '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    done       <= rst ? 1'b0 : fin.valid;
    norm_x     <= res[0];
    norm_y     <= res[1];
    norm_z     <= res[2];
    degenerate <= fin.degen;
  end

endmodule

// ----- hw/rtl/tfn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal checker
// Port-level properties of the normal pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tfn_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [15:0] norm_x,
  input logic [15:0] norm_y,
  input logic [15:0] norm_z,
  input logic        degenerate
);

  // No result transfer directly after a reset cycle.
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result transfer right after reset");

  // A degenerate result carries a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> norm_x == 16'h0 && norm_y == 16'h0 && norm_z == 16'h0)
    else $error("degenerate result with nonzero normal");

  // A proper triangle always yields a nonzero normal.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |-> norm_x != 16'h0 || norm_y != 16'h0 || norm_z != 16'h0)
    else $error("zero normal on a proper triangle");

  // Saturation never lets the most negative code through.
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    done |-> norm_x != 16'h8000 && norm_y != 16'h8000 && norm_z != 16'h8000)
    else $error("normal component at most negative code");

  // Outside reset the block is always ready for a new triangle.
  a_ready: assert property (@(posedge clk) !rst && !$past(rst) |-> !busy)
    else $error("busy outside reset");

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .norm_x    (norm_x),
  .norm_y    (norm_y),
  .norm_z    (norm_z),
  .degenerate(degenerate)
);
